[hdl/slcd_pkg.sv]
// ----------------------------------------------------------------------------
// Segment level-crossing detector: shared definitions
// Types, register indices, watch modes and a helper function.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam int DEF_NUM_WATCHES = 4;
    localparam int DEF_COORD_BITS  = 32;
    localparam int DEF_COUNT_BITS  = 16;

    localparam int MAX_WATCHES = 4;
    localparam int FIELD_BITS  = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [CFG_IDX_BITS-1:0] REG_WATCH_MODES = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_0    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_WINDOW    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_WINDOW    = 3'd6;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_X   = 2'd1;
    localparam logic [1:0] MODE_Y   = 2'd2;
    localparam logic [1:0] MODE_Z   = 2'd3;

    localparam logic OP_SEGMENT  = 1'b0;
    localparam logic OP_NEW_PLOT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_TEST,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_seg;
        logic clear_counts;
        logic watch_first;
        logic emit_first;
        logic watch_next;
        logic start_watch;
        logic mul;
        logic fix;
        logic test;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic pass;
        logic need_second;
        logic div_done;
        logic last_watch;
        logic out_free;
    } status_t;

    // Inclusive range test with the bounds in either order.
    function automatic logic between(logic signed [FIELD_BITS-1:0] v,
                                     logic signed [FIELD_BITS-1:0] a,
                                     logic signed [FIELD_BITS-1:0] b);
        logic r;
        if (a <= b) begin
            r = (v >= a) && (v <= b);
        end else begin
            r = (v >= b) && (v <= a);
        end
        return r;
    endfunction

endpackage

[hdl/slcd_divider.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of a 2N-bit dividend by an N-bit divisor, one quotient
// bit per cycle. The quotient is known to fit in N bits.
// ----------------------------------------------------------------------------
module slcd_divider #(
    parameter int N = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [2*N-1:0] dividend,
    input  logic [N-1:0]   divisor,
    output logic           done,
    output logic [N-1:0]   quotient
);
    localparam int CB = $clog2(N + 1);

    logic [N-1:0]  rem_reg, rem_next;
    logic [N-1:0]  lo_reg, lo_next;
    logic [N-1:0]  dvsr_reg, dvsr_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [N:0]    trial;
    logic [N:0]    diff;
    logic          ge;

    always_comb begin
        trial = {rem_reg, lo_reg[N-1]};
        ge    = trial >= {1'b0, dvsr_reg};
        diff  = trial - {1'b0, dvsr_reg};
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            rem_next  = dividend[2*N-1:N];
            lo_next   = dividend[N-1:0];
            dvsr_next = divisor;
            cnt_next  = CB'(N);
        end else if (cnt_reg != '0) begin
            rem_next = ge ? diff[N-1:0] : trial[N-1:0];
            lo_next  = {lo_reg[N-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = (cnt_reg == '0);
    assign quotient = lo_reg;

endmodule

[hdl/slcd_datapath.sv]
// ----------------------------------------------------------------------------
// Detector datapath
// Configuration, segment registers, interpolation, hit tests, per-watch
// counts and last hits, and the result register.
// ----------------------------------------------------------------------------
module slcd_datapath #(
    parameter int NUM_WATCHES = 4,
    parameter int COORD_BITS  = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  slcd_pkg::cmd_t                      cmd,
    output slcd_pkg::status_t                   status,
    input  logic [6*slcd_pkg::FIELD_BITS-1:0]   seg_data,
    input  logic                                cfg_we,
    input  logic [slcd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [slcd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [87:0]                         m_tdata,
    output logic                                m_tlast
);
    import slcd_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int WI = (NUM_WATCHES > 1) ? $clog2(NUM_WATCHES) : 1;

    // configuration
    logic [7:0]             modes_reg;
    logic signed [N-1:0]    target_reg [NUM_WATCHES];
    logic [63:0]            xwin_reg, ywin_reg;

    // segment
    logic signed [N-1:0] x1_reg, y1_reg, z1_reg, x2_reg, y2_reg, z2_reg;

    // watch walk
    logic [WI-1:0]          w_reg;
    logic [NUM_WATCHES-1:0] kept_reg;
    logic                   sel_reg;
    logic signed [N-1:0]    hx_reg, hy_reg;
    logic signed [N-1:0]    a1_reg;
    logic                   neg_reg;

    // per-watch state
    logic [COUNT_BITS-1:0] count_reg [NUM_WATCHES];
    logic signed [N-1:0]   prevx_reg [NUM_WATCHES];
    logic signed [N-1:0]   prevy_reg [NUM_WATCHES];

    // result register
    logic                  ovalid_reg;
    logic [WI-1:0]         oidx_reg;
    logic signed [N-1:0]   ox_reg, oy_reg;
    logic [COUNT_BITS-1:0] onum_reg;
    logic                  olast_reg;

    logic [1:0]          mode;
    logic signed [N-1:0] t, b1, b2, a1, a2;
    logic signed [N:0]   da, dn, dd;
    logic [N-1:0]        mda, mdn, mdd;
    logic [2*N-1:0]      prod;
    logic                neg;
    logic [N-1:0]        quot;
    logic                div_done;
    logic signed [N-1:0] res;
    logic                in_win, repeat_hit, keep, more_after;
    logic signed [N-1:0] wxa, wxb, wya, wyb;

    assign mode = modes_reg[2*w_reg +: 2];
    assign t    = target_reg[w_reg];
    assign wxa  = xwin_reg[N-1:0];
    assign wxb  = xwin_reg[32 +: N];
    assign wya  = ywin_reg[N-1:0];
    assign wyb  = ywin_reg[32 +: N];

    always_comb begin
        case (mode)
            MODE_X: begin
                b1 = x1_reg;
                b2 = x2_reg;
            end
            MODE_Y: begin
                b1 = y1_reg;
                b2 = y2_reg;
            end
            default: begin
                b1 = z1_reg;
                b2 = z2_reg;
            end
        endcase
        a1 = sel_reg ? y1_reg : x1_reg;
        a2 = sel_reg ? y2_reg : x2_reg;
        da = (N+1)'(a2) - (N+1)'(a1);
        dn = (N+1)'(t) - (N+1)'(b1);
        dd = (N+1)'(b2) - (N+1)'(b1);
        mda = da[N] ? N'(-da) : da[N-1:0];
        mdn = dn[N] ? N'(-dn) : dn[N-1:0];
        mdd = dd[N] ? N'(-dd) : dd[N-1:0];
        prod = mda * mdn;
        neg = (da[N] ^ dn[N] ^ dd[N]) && (da != '0) && (dn != '0);
        res = neg_reg ? a1_reg - N'(quot) : a1_reg + N'(quot);
        in_win = between(32'(hx_reg), 32'(wxa), 32'(wxb))
              && between(32'(hy_reg), 32'(wya), 32'(wyb));
        repeat_hit = (count_reg[w_reg] != '0) && (hx_reg == prevx_reg[w_reg])
                  && (hy_reg == prevy_reg[w_reg]);
        keep = in_win && !repeat_hit;
        more_after = 1'b0;
        for (int i = 0; i < NUM_WATCHES; i++) begin
            if (i > int'(w_reg) && kept_reg[i]) begin
                more_after = 1'b1;
            end
        end
    end

    slcd_divider #(.N(N)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mul),
        .dividend (prod),
        .divisor  (mdd),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb begin
        status.pass = (mode != MODE_OFF) && (b1 != b2)
                   && between(32'(t), 32'(b1), 32'(b2));
        status.need_second = (mode == MODE_Z) && !sel_reg;
        status.div_done    = div_done;
        status.last_watch  = (w_reg == WI'(NUM_WATCHES - 1));
        status.out_free    = !ovalid_reg || m_tready;
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modes_reg <= '0;
            xwin_reg  <= '0;
            ywin_reg  <= '0;
            for (int i = 0; i < NUM_WATCHES; i++) begin
                target_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index == REG_WATCH_MODES) begin
                modes_reg <= cfg_data[7:0];
            end
            if (cfg_index == REG_X_WINDOW) begin
                xwin_reg <= cfg_data;
            end
            if (cfg_index == REG_Y_WINDOW) begin
                ywin_reg <= cfg_data;
            end
            for (int i = 0; i < NUM_WATCHES; i++) begin
                if (cfg_index == REG_TARGET_0 + CFG_IDX_BITS'(i)) begin
                    target_reg[i] <= cfg_data[N-1:0];
                end
            end
        end
    end

    // walk control and per-watch counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg    <= '0;
            kept_reg <= '0;
            for (int i = 0; i < NUM_WATCHES; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            if (cmd.clear_counts) begin
                for (int i = 0; i < NUM_WATCHES; i++) begin
                    count_reg[i] <= '0;
                end
            end
            if (cmd.test && keep) begin
                if (count_reg[w_reg] != '1) begin
                    count_reg[w_reg] <= count_reg[w_reg] + 1'b1;
                end
                kept_reg[w_reg] <= 1'b1;
            end
            if (cmd.watch_first) begin
                w_reg    <= '0;
                kept_reg <= '0;
            end else if (cmd.emit_first) begin
                w_reg <= '0;
            end else if (cmd.watch_next) begin
                w_reg <= w_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_seg) begin
            x1_reg <= seg_data[0*32 +: N];
            y1_reg <= seg_data[1*32 +: N];
            z1_reg <= seg_data[2*32 +: N];
            x2_reg <= seg_data[3*32 +: N];
            y2_reg <= seg_data[4*32 +: N];
            z2_reg <= seg_data[5*32 +: N];
        end
        if (cmd.start_watch) begin
            hx_reg  <= t;
            hy_reg  <= t;
            sel_reg <= (mode == MODE_X);
        end
        if (cmd.mul) begin
            a1_reg  <= a1;
            neg_reg <= neg;
        end
        if (cmd.fix) begin
            if (sel_reg) begin
                hy_reg <= res;
            end else begin
                hx_reg <= res;
            end
            if (status.need_second) begin
                sel_reg <= 1'b1;
            end
        end
        if (cmd.test && keep) begin
            prevx_reg[w_reg] <= hx_reg;
            prevy_reg[w_reg] <= hy_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.emit && kept_reg[w_reg]) begin
            ovalid_reg <= 1'b1;
        end else if (m_tready) begin
            ovalid_reg <= 1'b0;
        end
        if (cmd.emit && kept_reg[w_reg]) begin
            oidx_reg  <= w_reg;
            ox_reg    <= prevx_reg[w_reg];
            oy_reg    <= prevy_reg[w_reg];
            onum_reg  <= count_reg[w_reg];
            olast_reg <= !more_after;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {6'd0, 16'(onum_reg), 32'(oy_reg), 32'(ox_reg), 2'(oidx_reg)};

endmodule

[hdl/slcd_ctrl.sv]
// ----------------------------------------------------------------------------
// Detector controller
// Clears the counts on a new-plot request. Walks the watches of one segment
// through check, interpolation and test, then delivers the kept hits in watch order.
// ----------------------------------------------------------------------------
module slcd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    input  slcd_pkg::status_t   status,
    output slcd_pkg::cmd_t      cmd
);
    import slcd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser == OP_SEGMENT) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.pass) begin
                    state_next = ST_MUL;
                end else if (status.last_watch) begin
                    state_next = ST_EMIT;
                end
            end
            ST_MUL: state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: state_next = status.need_second ? ST_MUL : ST_TEST;
            ST_TEST: state_next = status.last_watch ? ST_EMIT : ST_CHECK;
            ST_EMIT: begin
                if (status.out_free && status.last_watch) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.clear_counts = (s_tuser == OP_NEW_PLOT);
                    cmd.load_seg     = (s_tuser == OP_SEGMENT);
                    cmd.watch_first  = (s_tuser == OP_SEGMENT);
                end
            end
            ST_CHECK: begin
                cmd.start_watch = status.pass;
                cmd.watch_next  = !status.pass && !status.last_watch;
                cmd.emit_first  = !status.pass && status.last_watch;
            end
            ST_MUL: cmd.mul = 1'b1;
            ST_FIX: cmd.fix = 1'b1;
            ST_TEST: begin
                cmd.test       = 1'b1;
                cmd.watch_next = !status.last_watch;
                cmd.emit_first = status.last_watch;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.watch_next = !status.last_watch;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

[hdl/segment_level_crossing_detector.sv]
// ----------------------------------------------------------------------------
// Segment level-crossing detector
// Checks each 3-D segment against the configured watches, interpolates the
// crossing point and delivers every kept hit with its running count.
// ----------------------------------------------------------------------------
// Each segment is checked against every watch in turn; each interpolation runs
// on the shared serial divider (one per x or y watch, two per z watch), each
// watch that passes the check is then tested, and the kept hits are delivered
// in watch order, waiting while the result side stalls. A new-plot request
// only clears the counts. One request is worked on at a time. Reset (aresetn,
// synchronous, active low) clears configuration and counts.
module segment_level_crossing_detector #(
    parameter int NUM_WATCHES = slcd_pkg::DEF_NUM_WATCHES,
    parameter int COORD_BITS  = slcd_pkg::DEF_COORD_BITS,
    parameter int COUNT_BITS  = slcd_pkg::DEF_COUNT_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // x_start, y_start, z_start, x_end, y_end, z_end
    input  logic [191:0]                        s_tdata,
    // op
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // watch_index, hit_x, hit_y, hit_number, zero fill
    output logic [87:0]                         m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [slcd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [slcd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import slcd_pkg::*;

    cmd_t    cmd;
    status_t status;

    slcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    slcd_datapath #(
        .NUM_WATCHES (NUM_WATCHES),
        .COORD_BITS  (COORD_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .seg_data  (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
